@@ rtl/afhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afhc_pkg
// Shared types, register codes and the lens clamp/pack function for the
// hill-climb autofocus search.
// ----------------------------------------------------------------------------
package afhc_pkg;

   // Width of the sharpness value that takes part in the compare
   localparam int SHARPNESS_BITS = 32;
   localparam logic [31:0] SHARP_MASK =
      (SHARPNESS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SHARPNESS_BITS) - 64'd1);

   // Item commands
   localparam logic CMD_FRAME   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_POSITION = 2'd0;
   localparam logic [1:0] CSR_MAX_POSITION = 2'd1;
   localparam logic [1:0] CSR_STEP_SIZE    = 2'd2;
   localparam logic [1:0] CSR_PATIENCE     = 2'd3;

   // Reset values
   localparam logic [9:0] MIN_POSITION_RST = 10'd200;
   localparam logic [9:0] MAX_POSITION_RST = 10'd600;
   localparam logic [7:0] STEP_SIZE_RST    = 8'd10;
   localparam logic [3:0] PATIENCE_RST     = 4'd6;
   localparam logic [9:0] POSITION_RST     = 10'd200;

   localparam logic [3:0] COUNT_MAX = 4'hF;

   typedef struct packed {
      logic        command;
      logic [31:0] sharpness;
      logic [9:0]  start_position;
   } req_type;

   typedef struct packed {
      logic [9:0] lens_position;
      logic [5:0] high_byte;
      logic [7:0] low_byte;
      logic       focused;
   } rsp_type;

   typedef struct packed {
      logic [9:0] min_position;
      logic [9:0] max_position;
      logic [7:0] step_size;
      logic [3:0] patience;
   } cfg_type;

   // Clamp to max first, then raise to min; pack into the driver bytes
   function automatic rsp_type clamp_pack(input logic [10:0] pos, input logic done,
                                          input cfg_type cfg);
      logic [10:0] lim;
      rsp_type     r;
      lim = pos;
      if (lim > {1'b0, cfg.max_position}) lim = {1'b0, cfg.max_position};
      if (lim < {1'b0, cfg.min_position}) lim = {1'b0, cfg.min_position};
      r.lens_position = lim[9:0];
      r.high_byte     = lim[9:4];
      r.low_byte      = {lim[3:0], 4'b0000};
      r.focused       = done;
      return r;
   endfunction

endpackage

@@ rtl/afhc_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afhc_csr
// Configuration register file: four write-only search settings.
// ----------------------------------------------------------------------------
module afhc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata,
   output afhc_pkg::cfg_type cfg
);

   afhc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            afhc_pkg::CSR_MIN_POSITION: cfg_in.min_position = csr_wdata;
            afhc_pkg::CSR_MAX_POSITION: cfg_in.max_position = csr_wdata;
            afhc_pkg::CSR_STEP_SIZE:    cfg_in.step_size    = csr_wdata[7:0];
            afhc_pkg::CSR_PATIENCE:     cfg_in.patience     = csr_wdata[3:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_position <= afhc_pkg::MIN_POSITION_RST;
         cfg_ff.max_position <= afhc_pkg::MAX_POSITION_RST;
         cfg_ff.step_size    <= afhc_pkg::STEP_SIZE_RST;
         cfg_ff.patience     <= afhc_pkg::PATIENCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/afhc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afhc_core
// Search state and combinational step logic: best tracking, below-best count,
// lens stepping and the lock decision.
// ----------------------------------------------------------------------------
module afhc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  afhc_pkg::req_type item,
   input  afhc_pkg::cfg_type cfg,
   output logic              res_valid,
   output afhc_pkg::rsp_type res
);

   logic        locked_ff, locked_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] best_sharp_ff, best_sharp_in;
   logic [9:0]  best_pos_ff, best_pos_in;
   logic [10:0] cur_pos_ff, cur_pos_in;

   logic [31:0] sharp;
   logic [3:0]  count_next;
   logic [10:0] stepped;
   logic [10:0] res_pos;
   logic        res_done;

   always_comb begin
      sharp         = item.sharpness & afhc_pkg::SHARP_MASK;
      stepped       = cur_pos_ff + {3'b000, cfg.step_size};
      count_next    = 4'd0;
      locked_in     = locked_ff;
      count_in      = count_ff;
      best_sharp_in = best_sharp_ff;
      best_pos_in   = best_pos_ff;
      cur_pos_in    = cur_pos_ff;
      res_valid     = 1'b0;
      res_pos       = cur_pos_ff;
      res_done      = 1'b0;

      if (item.command == afhc_pkg::CMD_RESTART) begin
         locked_in     = 1'b0;
         count_in      = 4'd0;
         best_sharp_in = 32'd0;
         cur_pos_in    = {1'b0, item.start_position};
         best_pos_in   = item.start_position;
         res_valid     = 1'b1;
         res_pos       = {1'b0, item.start_position};
      end else if (!locked_ff) begin
         if (count_ff == cfg.patience || cur_pos_ff >= {1'b0, cfg.max_position}) begin
            // end of search: go back to the best position
            count_in  = 4'd0;
            locked_in = 1'b1;
            res_valid = 1'b1;
            res_pos   = {1'b0, best_pos_ff};
            res_done  = 1'b1;
         end else begin
            if (sharp > best_sharp_ff) begin
               best_pos_in   = cur_pos_ff[9:0];
               best_sharp_in = sharp;
            end
            if (sharp < best_sharp_ff) begin
               count_next = (count_ff == afhc_pkg::COUNT_MAX) ? count_ff : count_ff + 4'd1;
            end
            count_in = count_next;
            // count past patience (patience lowered mid-search): hold the lens
            if (count_next <= cfg.patience) begin
               cur_pos_in = stepped;
               res_valid  = 1'b1;
               res_pos    = stepped;
            end
         end
      end
   end

   assign res = afhc_pkg::clamp_pack(res_pos, res_done, cfg);

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff     <= 1'b0;
         count_ff      <= 4'd0;
         best_sharp_ff <= 32'd0;
         best_pos_ff   <= afhc_pkg::POSITION_RST;
         cur_pos_ff    <= {1'b0, afhc_pkg::POSITION_RST};
      end else if (fire) begin
         locked_ff     <= locked_in;
         count_ff      <= count_in;
         best_sharp_ff <= best_sharp_in;
         best_pos_ff   <= best_pos_in;
         cur_pos_ff    <= cur_pos_in;
      end
   end

endmodule

@@ rtl/autofocus_hill_climb_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autofocus_hill_climb_search_top
// Contrast-detect autofocus, hill-climb search: one sharpness item per frame
// in, zero or one clamped lens write out.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                          Handshake     Payload
//  -------   -----------------------------  ------------  -----------------
//  request   req_valid/req_ready/req_data    valid/ready   afhc_pkg::req_type
//  response  rsp_valid/rsp_ready/rsp_data    valid/ready   afhc_pkg::rsp_type
//  config    csr_we/csr_index/csr_wdata      write only    10-bit data
//
//  One item per cycle sustained while the response is not stalled. The item is
//  captured in the input register, the step logic runs against the search
//  state and the result lands in the response register.
//  A stalled response holds the input register; req_ready falls only while
//  both registers are full. Reset (synchronous) clears both valids, the
//  search state and the settings.
//
module autofocus_hill_climb_search_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  afhc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output afhc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata
);

   afhc_pkg::cfg_type cfg;

   // input register
   logic              in_valid_ff, in_valid_in;
   afhc_pkg::req_type in_data_ff;

   // response register
   logic              out_valid_ff, out_valid_in;
   afhc_pkg::rsp_type out_data_ff, out_data_in;

   logic              fire;
   logic              res_valid;
   afhc_pkg::rsp_type res;

   afhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   afhc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_data_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // the held item moves on when the response register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      if (fire) begin
         // frames while locked give no result; the register just drains
         out_valid_in = res_valid;
         out_data_in  = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/afhc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afhc_checker
// Port-level checks on the autofocus search top level.
// ----------------------------------------------------------------------------
module afhc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input afhc_pkg::rsp_type rsp_data
);

   // stalled response transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // driver bytes agree with the lens position
   a_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.high_byte == rsp_data.lens_position[9:4] &&
                    rsp_data.low_byte == {rsp_data.lens_position[3:0], 4'b0000})
      else $error("driver bytes do not match lens position");

   // request side only backs up behind a stalled response
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response stall");

   // nothing emerges straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind autofocus_hill_climb_search_top afhc_checker u_afhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
